// File: hw/rtl/adnp_pkg.sv
`default_nettype none

package adnp_pkg;

   // defaults for the top-level parameters
   localparam int MANTISSA_WIDTH_DEFAULT      = 63;
   localparam int MAX_FRACTION_DIGITS_DEFAULT = 31;

   // fixed field widths
   localparam int CHAR_WIDTH  = 8;
   localparam int VALUE_WIDTH = 64;
   localparam int FRAC_WIDTH  = 5;

   // result queue
   localparam int QUEUE_DEPTH = 4;

   // character codes
   localparam logic [CHAR_WIDTH-1:0] CHAR_ZERO  = 8'h30;
   localparam logic [CHAR_WIDTH-1:0] CHAR_NINE  = 8'h39;
   localparam logic [CHAR_WIDTH-1:0] CHAR_MINUS = 8'h2d;
   localparam logic [CHAR_WIDTH-1:0] CHAR_PLUS  = 8'h2b;
   localparam logic [CHAR_WIDTH-1:0] CHAR_POINT = 8'h2e;
   localparam logic [CHAR_WIDTH-1:0] CHAR_TAB   = 8'h09;
   localparam logic [CHAR_WIDTH-1:0] CHAR_CR    = 8'h0d;
   localparam logic [CHAR_WIDTH-1:0] CHAR_SPACE = 8'h20;

   typedef enum logic [1:0] {
      KIND_NUMBER  = 2'd0,
      KIND_INVALID = 2'd1,
      KIND_END     = 2'd2
   } kind_type;

   typedef struct packed {
      kind_type               kind;
      logic [VALUE_WIDTH-1:0] value;
      logic [FRAC_WIDTH-1:0]  frac;
      logic                   ovf;
      logic                   last;
   } result_type;

   // results produced by one accepted transaction (count is 0, 1 or 2)
   typedef struct packed {
      logic [1:0] count;
      result_type first;
      result_type second;
   } push_type;

   function automatic logic is_digit(input logic [CHAR_WIDTH-1:0] c);
      return c inside {[CHAR_ZERO:CHAR_NINE]};
   endfunction

   function automatic logic is_space(input logic [CHAR_WIDTH-1:0] c);
      return c inside {[CHAR_TAB:CHAR_CR], CHAR_SPACE};
   endfunction

endpackage

`default_nettype wire

// File: hw/rtl/adnp_parse_core.sv
`default_nettype none

module adnp_parse_core
   import adnp_pkg::*;
#(
   parameter int MANTISSA_WIDTH      = MANTISSA_WIDTH_DEFAULT,
   parameter int MAX_FRACTION_DIGITS = MAX_FRACTION_DIGITS_DEFAULT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  in_accept,
   input  wire logic                  in_end,
   input  wire logic [CHAR_WIDTH-1:0] in_char,
   output push_type                   push
);

   localparam int CW = $clog2(MAX_FRACTION_DIGITS + 1);
   localparam int PW = MANTISSA_WIDTH + 4;
   localparam int MW = MANTISSA_WIDTH;

   typedef enum logic [4:0] {
      MODE_IDLE       = 5'b00001,
      MODE_SIGN       = 5'b00010,
      MODE_SIGN_POINT = 5'b00100,
      MODE_INT        = 5'b01000,
      MODE_FRAC       = 5'b10000
   } mode_type;

   mode_type        mode_ff, mode_in;
   logic            neg_ff, neg_in;
   logic [MW-1:0]   mant_ff, mant_in;
   logic [CW-1:0]   cnt_ff, cnt_in;
   logic            sat_ff, sat_in;

   logic            is_dig, is_pt, is_sgn, is_sp;
   logic [3:0]      dval;
   logic [PW-1:0]   mant_ext, prod;
   logic            prod_ovf;

   logic [MW-1:0]   int_mant;
   logic            int_sat;
   logic            frac_ok;
   logic [MW-1:0]   frac_mant;
   logic [CW-1:0]   frac_cnt;
   logic            frac_sat;

   logic [VALUE_WIDTH-1:0] num_abs;
   logic [CW+FRAC_WIDTH-1:0] cnt_wide;
   result_type      num_res, bad_res, idle_res;

   mode_type        i_mode;
   logic            i_neg;
   logic [MW-1:0]   i_mant;
   logic            i_emit;

   logic            pre_emit, post_emit;
   result_type      pre_res;

   // character classes; a digit's value is its low nibble
   assign is_dig = !in_end && is_digit(in_char);
   assign is_pt  = !in_end && (in_char == CHAR_POINT);
   assign is_sgn = !in_end && ((in_char == CHAR_PLUS) || (in_char == CHAR_MINUS));
   assign is_sp  = !in_end && is_space(in_char);
   assign dval   = in_char[3:0];

   // mantissa * 10 + digit; overflow when it exceeds 2^MW - 1
   assign mant_ext = PW'(mant_ff);
   assign prod     = (mant_ext << 3) + (mant_ext << 1) + PW'(dval);
   assign prod_ovf = |prod[PW-1:MW];

   assign int_mant  = prod_ovf ? {MW{1'b1}} : prod[MW-1:0];
   assign int_sat   = sat_ff | prod_ovf;
   assign frac_ok   = (cnt_ff < CW'(MAX_FRACTION_DIGITS)) && !prod_ovf;
   assign frac_mant = frac_ok ? prod[MW-1:0] : mant_ff;
   assign frac_cnt  = frac_ok ? cnt_ff + CW'(1) : cnt_ff;
   assign frac_sat  = sat_ff | !frac_ok;

   assign num_abs  = VALUE_WIDTH'(mant_ff);
   assign cnt_wide = (CW + FRAC_WIDTH)'(cnt_ff);

   always_comb begin
      num_res       = '0;
      num_res.kind  = KIND_NUMBER;
      num_res.value = neg_ff ? (VALUE_WIDTH'(0) - num_abs) : num_abs;
      num_res.frac  = cnt_wide[FRAC_WIDTH-1:0];
      num_res.ovf   = sat_ff;
      bad_res       = '0;
      bad_res.kind  = KIND_INVALID;
   end

   // character handled from idle
   always_comb begin
      i_mode        = MODE_IDLE;
      i_neg         = 1'b0;
      i_mant        = '0;
      i_emit        = 1'b0;
      idle_res      = '0;
      idle_res.kind = KIND_INVALID;
      if (in_end) begin
         i_emit        = 1'b1;
         idle_res.kind = KIND_END;
      end else if (is_sp) begin
         i_emit = 1'b0;
      end else if (is_dig) begin
         i_mode = MODE_INT;
         i_mant = MW'(dval);
      end else if (is_sgn) begin
         i_mode = MODE_SIGN;
         i_neg  = (in_char == CHAR_MINUS);
      end else if (is_pt) begin
         i_mode = MODE_FRAC;
      end else begin
         i_emit = 1'b1;
      end
   end

   always_comb begin
      mode_in   = mode_ff;
      neg_in    = neg_ff;
      mant_in   = mant_ff;
      cnt_in    = cnt_ff;
      sat_in    = sat_ff;
      pre_emit  = 1'b0;
      post_emit = 1'b0;
      pre_res   = bad_res;
      case (mode_ff)
         MODE_SIGN: begin
            if (is_dig) begin
               mode_in = MODE_INT;
               mant_in = int_mant;
               sat_in  = int_sat;
            end else if (is_pt) begin
               mode_in = MODE_SIGN_POINT;
            end else begin
               pre_emit  = 1'b1;
               post_emit = 1'b1;
            end
         end
         MODE_SIGN_POINT: begin
            if (is_dig) begin
               mode_in = MODE_FRAC;
               mant_in = frac_mant;
               cnt_in  = frac_cnt;
               sat_in  = frac_sat;
            end else begin
               pre_emit  = 1'b1;
               post_emit = 1'b1;
            end
         end
         MODE_INT: begin
            if (is_dig) begin
               mant_in = int_mant;
               sat_in  = int_sat;
            end else if (is_pt) begin
               mode_in = MODE_FRAC;
            end else begin
               pre_emit  = 1'b1;
               pre_res   = num_res;
               post_emit = 1'b1;
            end
         end
         MODE_FRAC: begin
            if (is_dig) begin
               mant_in = frac_mant;
               cnt_in  = frac_cnt;
               sat_in  = frac_sat;
            end else begin
               pre_emit  = 1'b1;
               pre_res   = num_res;
               post_emit = 1'b1;
            end
         end
         default: begin
            post_emit = 1'b1;
         end
      endcase
      if (post_emit) begin
         mode_in = i_mode;
         neg_in  = i_neg;
         mant_in = i_mant;
         cnt_in  = '0;
         sat_in  = 1'b0;
      end
   end

   // pack up to two results, the final one flagged
   always_comb begin
      push        = '0;
      push.first  = pre_emit ? pre_res : idle_res;
      push.second = idle_res;
      if (in_accept) begin
         push.count = 2'(pre_emit) + 2'(post_emit && i_emit);
      end
      push.first.last  = (push.count == 2'd1);
      push.second.last = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_IDLE;
         neg_ff  <= 1'b0;
         mant_ff <= '0;
         cnt_ff  <= '0;
         sat_ff  <= 1'b0;
      end else if (in_accept) begin
         mode_ff <= mode_in;
         neg_ff  <= neg_in;
         mant_ff <= mant_in;
         cnt_ff  <= cnt_in;
         sat_ff  <= sat_in;
      end
   end

   a_sat_in_number: assert property (@(posedge clock) disable iff (reset)
      sat_ff |-> (mode_ff == MODE_INT) || (mode_ff == MODE_FRAC))
      else $error("saturation flag set outside a number");

   a_cnt_in_fraction: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff != '0) |-> (mode_ff == MODE_FRAC))
      else $error("fraction digits counted outside a fraction");

   a_pair_order: assert property (@(posedge clock) disable iff (reset)
      (push.count == 2'd2) |-> (push.first.kind != KIND_END) && !push.first.last)
      else $error("end mark not in final position of a result pair");

endmodule

`default_nettype wire

// File: hw/rtl/adnp_result_queue.sv
`default_nettype none

module adnp_result_queue
   import adnp_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   input  push_type  push,
   output logic      has_room,
   output logic      rsp_valid,
   input  wire logic rsp_ready,
   output result_type rsp_data
);

   localparam int AW = $clog2(QUEUE_DEPTH);

   result_type    entries_ff [QUEUE_DEPTH];
   logic [AW-1:0] wp_ff, wp_in, rp_ff, rp_in;
   logic [AW:0]   count_ff, count_in;
   logic          pop;

   assign rsp_valid = (count_ff != '0);
   assign rsp_data  = entries_ff[rp_ff];
   assign pop       = rsp_valid && rsp_ready;
   assign has_room  = (count_ff <= (AW + 1)'(QUEUE_DEPTH - 2));

   assign wp_in    = wp_ff + AW'(push.count);
   assign rp_in    = rp_ff + AW'(pop);
   assign count_in = count_ff + (AW + 1)'(push.count) - (AW + 1)'(pop);

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         entries_ff[wp_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         entries_ff[wp_ff + AW'(1)] <= push.second;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff    <= '0;
         rp_ff    <= '0;
         count_ff <= '0;
      end else begin
         wp_ff    <= wp_in;
         rp_ff    <= rp_in;
         count_ff <= count_in;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= (AW + 1)'(QUEUE_DEPTH))
      else $error("result queue count beyond depth");

   a_push_room: assert property (@(posedge clock) disable iff (reset)
      (push.count != 2'd0) |-> has_room)
      else $error("results pushed without room");

   a_pop_only: assert property (@(posedge clock) disable iff (reset)
      (push.count == 2'd0) && pop |=> (count_ff == $past(count_ff) - (AW + 1)'(1)))
      else $error("queue count not reduced by a lone pop");

endmodule

`default_nettype wire

// File: hw/rtl/ascii_decimal_number_parser_unit.sv
`default_nettype none
// ASCII decimal number parser.
// Input stream (req_*): one transaction per character; req_tuser high marks
// end of stream and req_tdata is then ignored. Whitespace is skipped; a
// number is an optional sign, integer digits, an optional point and fraction
// digits. The character that ends a number is handled again from idle.
// Result stream (rsp_*): rsp_tuser is the kind (number, invalid, end of
// stream); rsp_tdata carries the signed mantissa, the fraction digit count
// and the overflow flag; rsp_tlast marks the final result of one input.
// Results of a transaction accepted at one edge are written to the result
// queue at that edge and offered from the next cycle if the queue was empty.
// Throughput: one character per cycle while req_tready is high, set by the single
// multiply-by-ten-and-add in the parse core; an input that yields two results is offered as two result transactions.
// A four-entry result queue separates the sides: req_tready stays high while
// it holds two or fewer results, so a stalled receiver backs up the input
// once the queue holds three results. Synchronous reset empties the queue and
// returns the parser to idle with the number state cleared.
module ascii_decimal_number_parser_unit
   import adnp_pkg::*;
#(
   parameter int MANTISSA_WIDTH      = MANTISSA_WIDTH_DEFAULT,
   parameter int MAX_FRACTION_DIGITS = MAX_FRACTION_DIGITS_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] in_char
   input  wire logic        req_tuser,   // [0] op (1 = end of stream)
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [71:0]      rsp_tdata,   // [63:0] number_value, [68:64] fraction_digits,
                                         // [69] overflow, [71:70] zero
   output logic [1:0]       rsp_tuser,   // [1:0] kind
   output logic             rsp_tlast    // last_of_run
);

   push_type   push;
   result_type head;
   logic       has_room;
   logic       req_accept;

   // a transaction is taken only when the queue can absorb two results
   assign req_tready = has_room;
   assign req_accept = req_tvalid && req_tready;

   adnp_parse_core #(
      .MANTISSA_WIDTH      (MANTISSA_WIDTH),
      .MAX_FRACTION_DIGITS (MAX_FRACTION_DIGITS)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .in_accept (req_accept),
      .in_end    (req_tuser),
      .in_char   (req_tdata),
      .push      (push)
   );

   adnp_result_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .has_room  (has_room),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_data  (head)
   );

   assign rsp_tdata = {2'b00, head.ovf, head.frac, head.value};
   assign rsp_tuser = head.kind;
   assign rsp_tlast = head.last;

endmodule

`default_nettype wire

// File: bench/ascii_decimal_number_parser_unit_test.sv
`default_nettype none

// Character stream in, parsed numbers / invalid / end marks out.
// A directed table runs first, then about 1900 random characters built mostly
// from well-formed numbers. Every result is checked against a scoreboard fed by an
// in-bench parser on each accepted request, or by the results of a typed directed row.
module ascii_decimal_number_parser_unit_test
   import adnp_pkg::*;
;

   localparam int          PERIOD      = 12;
   localparam int          RANDOM_CHARS = 1900;
   localparam int          STALL_LIMIT = 1000;   // cycles with no transaction at all
   localparam logic [63:0] MANT_MAX    = (64'd1 << MANTISSA_WIDTH_DEFAULT) - 64'd1;
   localparam result_type  NO_RESULT   = '0;

   typedef enum logic [4:0] {
      ST_IDLE       = 5'b00001,
      ST_SIGN       = 5'b00010,
      ST_SIGN_POINT = 5'b00100,
      ST_INT        = 5'b01000,
      ST_FRAC       = 5'b10000
   } parse_state_type;

   // one directed stimulus row; typed rows carry their results written out
   typedef struct {
      logic        op;
      logic [7:0]  ch;
      bit          typed;
      int          n;
      result_type  r0;
      result_type  r1;
   } stim_row_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = '0;
   logic        req_tuser  = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [71:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        rsp_tlast;

   // no idling on either side while set
   logic        steady     = 1'b0;

   // parser copy kept by the bench
   parse_state_type parse_mode = ST_IDLE;
   logic         negative   = 1'b0;
   logic [63:0]  mantissa   = '0;
   int           frac_count = 0;
   logic         saturated  = 1'b0;
   result_type   step_results [2];
   int           step_count;

   result_type   pending_results [$];
   int           fails        = 0;
   int           chars_sent   = 0;
   int           stall_cycles = 0;

   always #(PERIOD / 2) clock = ~clock;

   ascii_decimal_number_parser_unit uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // ------------------------------------------------------------------
   // Bench-side parser
   // ------------------------------------------------------------------
   function automatic logic is_numeral(input logic [7:0] c);
      return c >= CHAR_ZERO && c <= CHAR_NINE;
   endfunction

   function automatic logic is_blank(input logic [7:0] c);
      return (c >= CHAR_TAB && c <= CHAR_CR) || c == CHAR_SPACE;
   endfunction

   // at most two results per transaction
   task automatic post_result(input kind_type k, input logic [63:0] v, input logic [4:0] f,
                              input logic o);
      if (step_count < 2) begin
         step_results[step_count] = '{kind: k, value: v, frac: f, ovf: o, last: 1'b0};
         step_count++;
      end
   endtask

   task automatic post_number();
      post_result(KIND_NUMBER, negative ? (64'd0 - mantissa) : mantissa, 5'(frac_count),
                  saturated);
   endtask

   // integer digit saturates at the mantissa maximum
   task automatic add_int_digit(input logic [63:0] d);
      if (mantissa > (MANT_MAX - d) / 64'd10) begin
         mantissa  = MANT_MAX;
         saturated = 1'b1;
      end else begin
         mantissa = mantissa * 64'd10 + d;
      end
   endtask

   // fraction digit is dropped on mantissa or digit-count overflow
   task automatic add_frac_digit(input logic [63:0] d);
      if (frac_count >= MAX_FRACTION_DIGITS_DEFAULT || mantissa > (MANT_MAX - d) / 64'd10) begin
         saturated = 1'b1;
      end else begin
         mantissa = mantissa * 64'd10 + d;
         frac_count++;
      end
   endtask

   // handling from idle; also used for the character that ends a number
   task automatic restart_idle(input logic eof, input logic [7:0] c);
      parse_mode = ST_IDLE;
      negative   = 1'b0;
      mantissa   = '0;
      frac_count = 0;
      saturated  = 1'b0;
      if (eof) begin
         post_result(KIND_END, '0, '0, 1'b0);
      end else if (is_blank(c)) begin
         // skipped
      end else if (is_numeral(c)) begin
         parse_mode = ST_INT;
         add_int_digit(64'(c - CHAR_ZERO));
      end else if (c == CHAR_PLUS || c == CHAR_MINUS) begin
         parse_mode = ST_SIGN;
         negative   = (c == CHAR_MINUS);
      end else if (c == CHAR_POINT) begin
         parse_mode = ST_FRAC;
      end else begin
         post_result(KIND_INVALID, '0, '0, 1'b0);
      end
   endtask

   task automatic parse_char(input logic eof, input logic [7:0] c);
      logic dig;
      dig        = !eof && is_numeral(c);
      step_count = 0;
      case (parse_mode)
         ST_SIGN: begin
            if (dig) begin
               parse_mode = ST_INT;
               add_int_digit(64'(c - CHAR_ZERO));
            end else if (!eof && c == CHAR_POINT) begin
               parse_mode = ST_SIGN_POINT;
            end else begin
               post_result(KIND_INVALID, '0, '0, 1'b0);
               restart_idle(eof, c);
            end
         end
         ST_SIGN_POINT: begin
            if (dig) begin
               parse_mode = ST_FRAC;
               add_frac_digit(64'(c - CHAR_ZERO));
            end else begin
               post_result(KIND_INVALID, '0, '0, 1'b0);
               restart_idle(eof, c);
            end
         end
         ST_INT: begin
            if (dig) begin
               add_int_digit(64'(c - CHAR_ZERO));
            end else if (!eof && c == CHAR_POINT) begin
               parse_mode = ST_FRAC;
            end else begin
               post_number();
               restart_idle(eof, c);
            end
         end
         ST_FRAC: begin
            if (dig) begin
               add_frac_digit(64'(c - CHAR_ZERO));
            end else begin
               post_number();
               restart_idle(eof, c);
            end
         end
         default: restart_idle(eof, c);
      endcase
      if (step_count > 0) step_results[step_count - 1].last = 1'b1;
   endtask

   // ------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------
   function automatic result_type res(input kind_type k, input logic [63:0] v,
                                      input logic last);
      return '{kind: k, value: v, frac: '0, ovf: 1'b0, last: last};
   endfunction

   function automatic stim_row_type plain(input logic op, input logic [7:0] ch);
      return '{op: op, ch: ch, typed: 1'b0, n: 0, r0: NO_RESULT, r1: NO_RESULT};
   endfunction

   function automatic stim_row_type typed_row(input logic op, input logic [7:0] ch, input int n,
                                              input result_type a, input result_type b);
      return '{op: op, ch: ch, typed: 1'b1, n: n, r0: a, r1: b};
   endfunction

   function automatic logic [7:0] blank_char();
      int unsigned k;
      k = $urandom_range(0, 5);
      return (k == 5) ? CHAR_SPACE : 8'(CHAR_TAB + k);
   endfunction

   // any byte that neither continues a number nor starts a fraction
   function automatic logic [7:0] stray_char();
      logic [7:0] c;
      do c = 8'($urandom_range(0, 255)); while (is_numeral(c) || c == CHAR_POINT);
      return c;
   endfunction

   // Drives one request transaction. Called and returns at a rising edge; the
   // handshake is sampled at the falling edge, where all signals are settled.
   task automatic send_item(input stim_row_type row);
      steady <= (chars_sent >= 900 && chars_sent < 1200);
      if (!steady && $urandom_range(0, 99) < 20) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 2)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= row.op;
      req_tdata  <= row.ch;
      do @(negedge clock); while (!req_tready);
      parse_char(row.op, row.ch);
      if (row.typed) begin
         if (row.n > 0) pending_results.push_back(row.r0);
         if (row.n > 1) pending_results.push_back(row.r1);
      end else begin
         for (int i = 0; i < step_count; i++) pending_results.push_back(step_results[i]);
      end
      chars_sent++;
      @(posedge clock);
   endtask

   task automatic send_plain(input logic op, input logic [7:0] ch);
      send_item(plain(op, ch));
   endtask

   // ------------------------------------------------------------------
   // Result side: random backpressure, scoreboard check, watchdog
   // ------------------------------------------------------------------
   always @(posedge clock) rsp_tready <= steady || ($urandom_range(0, 99) >= 20);

   always @(negedge clock) begin
      result_type exp;
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            stall_cycles = 0;
         end else begin
            stall_cycles++;
         end
         if (stall_cycles >= STALL_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
         end else if (rsp_tvalid && rsp_tready) begin
            if (pending_results.size() == 0) begin
               $error("unexpected result transaction, kind %0d", rsp_tuser);
               fails++;
            end else begin
               exp = pending_results.pop_front();
               if (rsp_tuser != exp.kind) begin
                  $error("kind: expected %0d, actual %0d", exp.kind, rsp_tuser);
                  fails++;
               end
               if (rsp_tdata[63:0] != exp.value) begin
                  $error("number_value: expected %0d, actual %0d", $signed(exp.value),
                         $signed(rsp_tdata[63:0]));
                  fails++;
               end
               if (rsp_tdata[68:64] != exp.frac) begin
                  $error("fraction_digits: expected %0d, actual %0d", exp.frac,
                         rsp_tdata[68:64]);
                  fails++;
               end
               if (rsp_tdata[69] != exp.ovf) begin
                  $error("overflow: expected %0d, actual %0d", exp.ovf, rsp_tdata[69]);
                  fails++;
               end
               if (rsp_tlast != exp.last) begin
                  $error("last_of_run: expected %0d, actual %0d", exp.last, rsp_tlast);
                  fails++;
               end
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------
   initial begin
      stim_row_type directed [27];
      int unsigned pick;
      int unsigned int_len;
      int unsigned frac_len;
      logic        has_point;
      logic        zero_run;

      // EOF rows carry a junk byte in tdata to show it is ignored
      directed = '{
         typed_row(1'b1, 8'hA5, 1, res(KIND_END, '0, 1'b1), NO_RESULT),       // end from reset
         typed_row(1'b0, "x", 1, res(KIND_INVALID, '0, 1'b1), NO_RESULT),
         typed_row(1'b0, 8'hFF, 1, res(KIND_INVALID, '0, 1'b1), NO_RESULT),
         typed_row(1'b0, 8'h00, 1, res(KIND_INVALID, '0, 1'b1), NO_RESULT),
         typed_row(1'b0, CHAR_SPACE, 0, NO_RESULT, NO_RESULT),
         typed_row(1'b0, CHAR_TAB, 0, NO_RESULT, NO_RESULT),
         typed_row(1'b0, CHAR_CR, 0, NO_RESULT, NO_RESULT),
         plain(1'b0, CHAR_MINUS),
         // sign cut off by end of stream: invalid, then the end mark
         typed_row(1'b1, 8'h5A, 2, res(KIND_INVALID, '0, 1'b0), res(KIND_END, '0, 1'b1)),
         plain(1'b0, CHAR_PLUS),
         plain(1'b0, CHAR_POINT),
         // sign and point without a digit, then the letter itself from idle
         typed_row(1'b0, "a", 2, res(KIND_INVALID, '0, 1'b0), res(KIND_INVALID, '0, 1'b1)),
         plain(1'b0, CHAR_POINT),
         // a lone point reads as zero
         typed_row(1'b0, CHAR_SPACE, 1, res(KIND_NUMBER, '0, 1'b1), NO_RESULT),
         plain(1'b0, "9"),
         plain(1'b0, CHAR_POINT),
         plain(1'b0, "5"),
         plain(1'b0, ","),
         plain(1'b0, CHAR_MINUS),
         plain(1'b0, "7"),
         plain(1'b0, CHAR_SPACE),
         plain(1'b0, "3"),
         // end of stream inside a number: number first, then the end mark
         typed_row(1'b1, 8'hC3, 2, res(KIND_NUMBER, 64'd3, 1'b0), res(KIND_END, '0, 1'b1)),
         plain(1'b0, CHAR_MINUS),
         plain(1'b0, CHAR_POINT),
         plain(1'b0, "1"),
         plain(1'b1, 8'h3C)
      };

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (directed[i]) send_item(directed[i]);

      chars_sent = 0;
      while (chars_sent < RANDOM_CHARS) begin
         pick = $urandom_range(0, 99);
         if (pick < 60) begin
            // well-formed number with random content
            repeat ($urandom_range(0, 2)) send_plain(1'b0, blank_char());
            case ($urandom_range(0, 2))
               1: send_plain(1'b0, CHAR_PLUS);
               2: send_plain(1'b0, CHAR_MINUS);
               default: ;
            endcase
            pick = $urandom_range(0, 99);
            int_len = (pick < 70) ? $urandom_range(0, 6) :
                      (pick < 90) ? $urandom_range(7, 18) : $urandom_range(19, 24);
            has_point = 1'($urandom_range(0, 1));
            pick = $urandom_range(0, 99);
            frac_len = (pick < 75) ? $urandom_range(0, 5) :
                       (pick < 95) ? $urandom_range(6, 20) : $urandom_range(25, 40);
            // long runs of zeros keep the mantissa small and hit the digit-count cap
            zero_run = (frac_len >= 25) && $urandom_range(0, 1);
            if (int_len == 0 && !has_point) int_len = 1;
            repeat (int_len) send_plain(1'b0, 8'(CHAR_ZERO + $urandom_range(0, 9)));
            if (has_point) begin
               send_plain(1'b0, CHAR_POINT);
               repeat (frac_len)
                  send_plain(1'b0, zero_run ? CHAR_ZERO : 8'(CHAR_ZERO + $urandom_range(0, 9)));
            end
            pick = $urandom_range(0, 99);
            if (pick < 50) send_plain(1'b0, blank_char());
            else if (pick < 65) send_plain(1'b1, 8'($urandom_range(0, 255)));
            else if (pick < 80) send_plain(1'b0, 8'($urandom_range(0, 255)));
            // otherwise the next token follows right on
         end else if (pick < 75) begin
            // noise
            repeat ($urandom_range(1, 4)) send_plain(1'b0, 8'($urandom_range(0, 255)));
         end else if (pick < 85) begin
            // broken: sign, maybe a point, then no digit
            send_plain(1'b0, $urandom_range(0, 1) ? CHAR_PLUS : CHAR_MINUS);
            if ($urandom_range(0, 1)) send_plain(1'b0, CHAR_POINT);
            if ($urandom_range(0, 99) < 30) send_plain(1'b1, 8'($urandom_range(0, 255)));
            else send_plain(1'b0, stray_char());
         end else if (pick < 90) begin
            send_plain(1'b1, 8'($urandom_range(0, 255)));
         end else begin
            // lone point, or point followed by a second point
            send_plain(1'b0, CHAR_POINT);
            if ($urandom_range(0, 1)) send_plain(1'b0, CHAR_POINT);
            send_plain(1'b0, stray_char());
         end
      end
      req_tvalid <= 1'b0;
      steady     <= 1'b0;

      // drain: the watchdog catches a result that never comes
      while (pending_results.size() != 0) @(negedge clock);
      repeat (8) @(posedge clock);

      if (fails == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

`default_nettype wire

// File: sim.f
hw/rtl/adnp_pkg.sv
hw/rtl/adnp_parse_core.sv
hw/rtl/adnp_result_queue.sv
hw/rtl/ascii_decimal_number_parser_unit.sv
bench/ascii_decimal_number_parser_unit_test.sv
